### design/farthest_insertion_tour_builder_macros.svh
// Assertion macros for the farthest insertion tour builder.
// Used by fitb_back, which checks its own control logic; needs clk and rst_n in scope.
`ifndef FARTHEST_INSERTION_TOUR_BUILDER_MACROS_SVH
`define FARTHEST_INSERTION_TOUR_BUILDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FITB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FITB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FITB_ASSERT_IMP(label, ante, cons, msg)
`define FITB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### design/fitb_pkg.sv
// Shared types and constants for the farthest insertion tour builder.
// No dependencies.
package fitb_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        last_point;
  } in_item_t;

  typedef struct packed {
    logic [4:0] city_index;
    logic       last_in_tour;
  } out_item_t;

  typedef enum logic {
    CMD_POINT = 1'b0,
    CMD_BUILD = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    in_item_t  item;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

### design/fitb_front.sv
// Front end: takes input transfers, classifies them and queues them for the builder.
// Depends on fitb_pkg.
module fitb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fitb_pkg::in_item_t in_item,
  input  logic               q_pop,
  output fitb_pkg::q_head_t  q_head
);

  fitb_pkg::cmd_t            q_mem [fitb_pkg::QDEPTH];
  logic [fitb_pkg::QAW-1:0]  wp_r, rp_r;
  logic [fitb_pkg::QAW:0]    cnt_r;
  logic                      push;
  fitb_pkg::cmd_t            cmd_in;

  assign busy = (cnt_r == (fitb_pkg::QAW+1)'(fitb_pkg::QDEPTH));
  assign push = start && !busy;

  always_comb begin
    cmd_in.item = in_item;
    cmd_in.kind = in_item.last_point ? fitb_pkg::CMD_BUILD : fitb_pkg::CMD_POINT;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_mem[rp_r];

endmodule

### design/fitb_sqrt.sv
// Iterative bitwise square root, two radicand bits per cycle, with fraction bits.
// No dependencies.
module fitb_sqrt #(
  parameter int CB        = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [2*CB:0]           radicand,
  output logic                    done,
  output logic [CB+FRAC_BITS:0]   root
);

  localparam int HP    = CB + 1;
  localparam int PW    = 2 * HP;
  localparam int RW    = CB + 1 + FRAC_BITS;
  localparam int NSTEP = HP + FRAC_BITS;
  localparam int KW    = $clog2(NSTEP + 1);

  logic [PW-1:0] s_r;
  logic [RW-1:0] root_r, root_nxt;
  logic [RW+1:0] rem_r, rem_nxt;
  logic [KW-1:0] k_r;
  logic          run_r, done_r;
  logic [RW+3:0] rem_sh;
  logic [RW+1:0] trial;

  always_comb begin
    rem_sh = {rem_r, s_r[PW-1:PW-2]};
    trial  = {root_r, 2'b01};
    if (rem_sh >= (RW+4)'(trial)) begin
      rem_nxt  = (RW+2)'(rem_sh - (RW+4)'(trial));
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[RW+1:0];
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        k_r   <= KW'(NSTEP);
      end else if (run_r) begin
        k_r <= k_r - 1'b1;
        if (k_r == KW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s_r    <= PW'(radicand);
      root_r <= '0;
      rem_r  <= '0;
    end else if (run_r) begin
      s_r    <= {s_r[PW-3:0], 2'b00};
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### design/fitb_back.sv
// Back end: stores points, fills the distance memory, builds the tour and emits it.
// Depends on fitb_pkg, fitb_sqrt and the assertion macro header.
`include "farthest_insertion_tour_builder_macros.svh"
module fitb_back #(
  parameter int NUM_POINTS = 32,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fitb_pkg::q_head_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  output fitb_pkg::out_item_t out_res
);

  localparam int IW   = $clog2(NUM_POINTS);
  localparam int CW   = $clog2(NUM_POINTS + 1);
  localparam int CB   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SW   = 2 * CB + 1;
  localparam int DW   = CB + 1 + FRAC_BITS;
  localparam int CSTW = (DW + 2 > FRAC_BITS + 18) ? DW + 2 : FRAC_BITS + 18;
  localparam int DA   = 2 * IW;
  localparam logic signed [CSTW-1:0] COST_CEIL = CSTW'(100000 * (2 ** FRAC_BITS));

  typedef enum logic [4:0] {
    ST_IDLE, ST_DA, ST_DB, ST_DC, ST_DM1, ST_DM2, ST_DR, ST_SETUP,
    ST_ST, ST_SA, ST_SD, ST_SC, ST_ETA, ST_ETB, ST_ER1, ST_ER2, ST_ER3, ST_EC,
    ST_IRD, ST_IWR, ST_IPUT, ST_ORD, ST_OWR, ST_OEND
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           cnt_r, tlen_r, i_r, j_r, pos_r;
  logic [NUM_POINTS-1:0]   flags_r;
  logic [IW-1:0]           a_r, b_r, pick_r;
  logic [2*CB-1:0]         pa_r;
  logic [CB-1:0]           dx_r, dy_r;
  logic [2*CB-1:0]         sq_r;
  logic                    found_r;
  logic [DW-1:0]           best_r, dap_r, dpb_r;
  logic signed [CSTW-1:0]  least_r, cost_w;
  logic                    out_valid_r;
  fitb_pkg::out_item_t     out_r;

  logic [2*CB-1:0] pmem [NUM_POINTS];
  logic [2*CB-1:0] pq_r, p_wd;
  logic [IW-1:0]   p_wa, p_ra;
  logic            p_we;

  logic [DW-1:0]   dmem [2**DA];
  logic [DW-1:0]   dq_r, d_wd;
  logic [DA-1:0]   d_wa, d_ra;
  logic            d_we;

  logic [IW-1:0]   tmem [NUM_POINTS+1];
  logic [IW-1:0]   tq_r, t_wd;
  logic [CW-1:0]   t_wa, t_ra;
  logic            t_we;

  logic            sq_go, sq_done;
  logic [SW-1:0]   sq_sum;
  logic [DW-1:0]   sq_root;
  logic [CB-1:0]   bx, by, ax, ay;
  logic            sel_hit;

  fitb_sqrt #(.CB(CB), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go),
    .radicand (sq_sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    pq_r <= pmem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_wa] <= d_wd;
    end
    dq_r <= dmem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    tq_r <= tmem[t_ra];
  end

  assign ax = pa_r[CB-1:0];
  assign ay = pa_r[2*CB-1:CB];
  assign bx = pq_r[CB-1:0];
  assign by = pq_r[2*CB-1:CB];
  assign sq_sum = SW'(sq_r) + SW'((2*CB)'(dy_r) * (2*CB)'(dy_r));
  assign sel_hit = !flags_r[j_r[IW-1:0]] && (!found_r || (dq_r > best_r));
  assign cost_w = CSTW'(dap_r) + CSTW'(dpb_r) - CSTW'(dq_r);

  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_head.valid;
    p_we  = q_pop && (cnt_r < CW'(NUM_POINTS));
    p_wa  = cnt_r[IW-1:0];
    p_wd  = {q_head.cmd.item.y_coord[CB-1:0], q_head.cmd.item.x_coord[CB-1:0]};
    p_ra  = (state_r == ST_DA) ? i_r[IW-1:0] : j_r[IW-1:0];
    sq_go = (state_r == ST_DM2);
    d_we  = (state_r == ST_DR) && sq_done;
    d_wa  = {i_r[IW-1:0], j_r[IW-1:0]};
    d_wd  = sq_root;
    unique case (state_r)
      ST_ER1:  d_ra = {a_r, pick_r};
      ST_ER2:  d_ra = {pick_r, b_r};
      ST_ER3:  d_ra = {a_r, b_r};
      default: d_ra = {a_r, j_r[IW-1:0]};
    endcase
    t_we = 1'b0;
    t_wa = j_r;
    t_wd = tq_r;
    unique case (state_r)
      ST_SETUP: begin
        t_we = 1'b1;
        t_wa = '0;
        t_wd = '0;
      end
      ST_IWR: t_we = 1'b1;
      ST_IPUT: begin
        t_we = 1'b1;
        t_wa = pos_r;
        t_wd = pick_r;
      end
      default: t_we = 1'b0;
    endcase
    unique case (state_r)
      ST_ETB:  t_ra = i_r + 1'b1;
      ST_IRD:  t_ra = j_r - 1'b1;
      ST_ORD:  t_ra = j_r;
      default: t_ra = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tlen_r      <= '0;
      flags_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (p_we) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (q_head.cmd.kind == fitb_pkg::CMD_BUILD) begin
              i_r     <= '0;
              j_r     <= '0;
              state_r <= ST_DA;
            end
          end
        end
        ST_DA: state_r <= ST_DB;
        ST_DB: begin
          pa_r    <= pq_r;
          state_r <= ST_DC;
        end
        ST_DC: begin
          dx_r    <= (ax > bx) ? ax - bx : bx - ax;
          dy_r    <= (ay > by) ? ay - by : by - ay;
          state_r <= ST_DM1;
        end
        ST_DM1: begin
          sq_r    <= (2*CB)'(dx_r) * (2*CB)'(dx_r);
          state_r <= ST_DM2;
        end
        ST_DM2: state_r <= ST_DR;
        ST_DR: begin
          if (sq_done) begin
            if (j_r + 1'b1 == cnt_r) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
              state_r <= (i_r + 1'b1 == cnt_r) ? ST_SETUP : ST_DA;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= ST_DA;
            end
          end
        end
        ST_SETUP: begin
          flags_r    <= NUM_POINTS'(1);
          tlen_r     <= CW'(1);
          found_r    <= 1'b0;
          i_r        <= '0;
          state_r    <= ST_ST;
        end
        ST_ST: state_r <= ST_SA;
        ST_SA: begin
          a_r     <= tq_r;
          j_r     <= '0;
          state_r <= ST_SD;
        end
        ST_SD: state_r <= ST_SC;
        ST_SC: begin
          if (sel_hit) begin
            found_r <= 1'b1;
            best_r  <= dq_r;
            pick_r  <= j_r[IW-1:0];
            pos_r   <= i_r + 1'b1;
          end
          if (j_r + 1'b1 == cnt_r) begin
            if (i_r + 1'b1 == tlen_r) begin
              least_r <= COST_CEIL;
              i_r     <= '0;
              j_r     <= '0;
              if (!(found_r || sel_hit)) begin
                state_r <= ST_ORD;
              end else if (tlen_r >= CW'(2)) begin
                state_r <= ST_ETA;
              end else begin
                j_r     <= tlen_r;
                state_r <= ST_IRD;
              end
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= ST_ST;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_SD;
          end
        end
        ST_ETA: state_r <= ST_ETB;
        ST_ETB: begin
          a_r     <= tq_r;
          state_r <= ST_ER1;
        end
        ST_ER1: begin
          b_r     <= tq_r;
          state_r <= ST_ER2;
        end
        ST_ER2: state_r <= ST_ER3;
        ST_ER3: state_r <= ST_EC;
        ST_EC: begin
          if (cost_w < least_r) begin
            least_r <= cost_w;
            pos_r   <= i_r + 1'b1;
          end
          if (i_r + CW'(2) == tlen_r) begin
            j_r     <= tlen_r;
            state_r <= ST_IRD;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_ETA;
          end
        end
        ST_IRD: begin
          if (j_r == pos_r) begin
            state_r <= ST_IPUT;
          end else begin
            state_r <= ST_IWR;
          end
        end
        ST_IWR: begin
          j_r     <= j_r - 1'b1;
          state_r <= ST_IRD;
        end
        ST_IPUT: begin
          flags_r[pick_r] <= 1'b1;
          tlen_r          <= tlen_r + 1'b1;
          found_r         <= 1'b0;
          i_r             <= '0;
          state_r         <= ST_ST;
        end
        ST_ORD: state_r <= ST_OWR;
        ST_OWR: begin
          out_valid_r        <= 1'b1;
          out_r.city_index   <= 5'(tq_r);
          out_r.last_in_tour <= 1'b0;
          j_r                <= j_r + 1'b1;
          state_r            <= (j_r + 1'b1 == tlen_r) ? ST_OEND : ST_ORD;
        end
        ST_OEND: begin
          out_valid_r        <= 1'b1;
          out_r.city_index   <= '0;
          out_r.last_in_tour <= 1'b1;
          cnt_r              <= '0;
          tlen_r             <= '0;
          flags_r            <= '0;
          state_r            <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The first and second operands of the cost are each latched as their read lands.
  always_ff @(posedge clk) begin
    if (state_r == ST_ER2) begin
      dap_r <= dq_r;
    end
    if (state_r == ST_ER3) begin
      dpb_r <= dq_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `FITB_ASSERT_NEXT(a_end_gap, out_valid_r && out_r.last_in_tour, !out_valid_r, "strobe after tour end")
  `FITB_ASSERT_IMP(a_tlen_cap, 1'b1, tlen_r <= cnt_r, "tour longer than point set")
  `FITB_ASSERT_IMP(a_root_in, state_r == ST_ST, flags_r[0], "point 0 missing from tour")
  `FITB_ASSERT_IMP(a_pick_new, state_r == ST_IPUT, !flags_r[pick_r], "point inserted twice")

endmodule

### design/farthest_insertion_tour_builder.sv
// Top level of the farthest insertion tour builder.
// Depends on fitb_pkg, fitb_front and fitb_back.
//
//  channel | ports                       | handshake
//  input   | start, busy, in_item        | transfer when start is high and busy low
//  result  | out_valid, out_res          | one-cycle strobe, always taken
//
// A point transfer enters a four-entry queue; the back end stores it when it pops it while idle.
// A build fills the n*n distance table through the serial square root, then scans the
// distance memory's single read port in each insertion round, and then emits the tour
// positions.
// Reset is synchronous and clears all control state; busy is high only while the queue is full.
module farthest_insertion_tour_builder #(
  parameter int NUM_POINTS = 32,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fitb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fitb_pkg::out_item_t out_res
);

  fitb_pkg::q_head_t q_head;
  logic              q_pop;

  fitb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  fitb_back #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### test/farthest_insertion_tour_builder_checker.sv
`timescale 1ns / 1ps
// Checker for the farthest insertion tour builder: watches both channels, predicts each tour
// and compares every result transfer with it. Depends on fitb_pkg.
module farthest_insertion_tour_builder_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  fitb_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  fitb_pkg::out_item_t out_res,
  output int                  fails,
  output int                  pending,
  output int                  builds
);

  localparam int CAPACITY  = 32;
  localparam int FRAC      = 8;
  localparam longint CEILING = longint'(100000) << FRAC;

  logic [15:0]         px[CAPACITY];
  logic [15:0]         py[CAPACITY];
  int                  loaded;
  fitb_pkg::out_item_t tour_q[$];

  assign pending = tour_q.size();

  function automatic longint unsigned exact_root(longint unsigned s);
    longint unsigned root, rem, trial;
    root = 0;
    rem  = 0;
    for (int k = 31 + FRAC; k >= 0; k--) begin
      trial = (root << 2) | 1;
      rem = (rem << 2) | ((k >= FRAC) ? ((s >> (2 * (k - FRAC))) & 3) : 0);
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned gap_between(int a, int b);
    longint unsigned dx, dy;
    dx = (px[a] > px[b]) ? px[a] - px[b] : px[b] - px[a];
    dy = (py[a] > py[b]) ? py[a] - py[b] : py[b] - py[a];
    return exact_root(dx * dx + dy * dy);
  endfunction

  task automatic predict_tour();
    longint unsigned     dtab[CAPACITY][CAPACITY];
    int                  tour[CAPACITY + 1];
    bit                  placed[CAPACITY];
    int                  len, pick, pos;
    bit                  found;
    longint unsigned     best;
    longint              least, cost;
    fitb_pkg::out_item_t r;
    for (int i = 0; i < loaded; i++)
      for (int j = 0; j < loaded; j++)
        dtab[i][j] = gap_between(i, j);
    for (int i = 0; i < CAPACITY; i++) placed[i] = 0;
    tour[0] = 0;
    placed[0] = 1;
    len = 1;
    for (int round = 0; round < loaded; round++) begin
      found = 0;
      best  = 0;
      pick  = 0;
      pos   = 0;
      least = CEILING;
      for (int i = 0; i < len; i++)
        for (int j = 0; j < loaded; j++)
          if (!placed[j] && (!found || dtab[tour[i]][j] > best)) begin
            found = 1;
            best  = dtab[tour[i]][j];
            pick  = j;
            pos   = i + 1;
          end
      if (!found) break;
      for (int i = 0; i + 1 < len; i++) begin
        cost = longint'(dtab[tour[i]][pick]) + longint'(dtab[pick][tour[i + 1]])
             - longint'(dtab[tour[i]][tour[i + 1]]);
        if (cost < least) begin
          least = cost;
          pos   = i + 1;
        end
      end
      for (int k = len; k > pos; k--) tour[k] = tour[k - 1];
      tour[pos] = pick;
      placed[pick] = 1;
      len++;
    end
    for (int k = 0; k < len; k++) begin
      r.city_index   = tour[k][4:0];
      r.last_in_tour = 1'b0;
      tour_q.push_back(r);
    end
    r.city_index   = '0;
    r.last_in_tour = 1'b1;
    tour_q.push_back(r);
  endtask

  always @(posedge clk) begin
    fitb_pkg::out_item_t want;
    if (!rst_n) begin
      loaded = 0;
      fails  <= 0;
      builds <= 0;
      tour_q.delete();
    end else begin
      if (out_valid) begin
        if (tour_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("ERROR: unexpected result %p", out_res);
        end else begin
          want = tour_q.pop_front();
          if (out_res.city_index !== want.city_index ||
              out_res.last_in_tour !== want.last_in_tour) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("ERROR: expected city %0d last %0b, got city %0d last %0b",
                       want.city_index, want.last_in_tour,
                       out_res.city_index, out_res.last_in_tour);
          end
        end
      end
      if (start && !busy) begin
        if (loaded < CAPACITY) begin
          px[loaded] = in_item.x_coord;
          py[loaded] = in_item.y_coord;
          loaded = loaded + 1;
        end
        if (in_item.last_point) begin
          predict_tour();
          loaded = 0;
          builds <= builds + 1;
        end
      end
    end
  end
endmodule

### test/farthest_insertion_tour_builder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the farthest insertion tour builder: directed and random point sets with
// random gaps; prediction and comparison sit in the checker module. Depends on fitb_pkg.
module farthest_insertion_tour_builder_tb;

  localparam int WATCHDOG_LIMIT = 500000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  fitb_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  fitb_pkg::out_item_t out_res;
  int                  fails, pending, builds;
  int                  points_sent = 0;
  int                  idle_cycles = 0;

  always #10 clk = ~clk;

  farthest_insertion_tour_builder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_res(out_res)
  );

  farthest_insertion_tour_builder_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_res(out_res),
    .fails(fails), .pending(pending), .builds(builds)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("farthest_insertion_tour_builder_tb failed");
        $finish;
      end
    end
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last, int gap);
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{x_coord: x, y_coord: y, last_point: last};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    points_sent++;
  endtask

  task automatic send_set(int size, int shape, bit gaps);
    logic [15:0] x, y;
    for (int i = 0; i < size; i++) begin
      case (shape)
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        1: begin
          x = 16'($urandom_range(0, 3));
          y = 16'($urandom_range(0, 3));
        end
        default: begin
          x = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
          y = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
      endcase
      send_point(x, y, i == size - 1, gaps ? $urandom_range(0, 15) : 0);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(16'd0, 16'd0, 1'b1, 0);
    send_point(16'd0, 16'd0, 1'b0, 0);
    send_point(16'hffff, 16'hffff, 1'b1, 3);
    for (int i = 0; i < 3; i++) send_point(16'd7, 16'd7, i == 2, 0);
    send_point(16'd0, 16'd0, 1'b0, 1);
    send_point(16'd10, 16'd0, 1'b0, 0);
    send_point(16'd20, 16'd0, 1'b0, 0);
    send_point(16'd5, 16'd0, 1'b1, 0);
    send_point(16'hffff, 16'h0000, 1'b0, 2);
    send_point(16'h0000, 16'hffff, 1'b0, 0);
    send_point(16'h8000, 16'h8000, 1'b1, 0);
    drain();
    send_set(35, 0, 1'b1);

    while (points_sent < 350) begin
      if ($urandom_range(0, 24) == 0)
        send_set($urandom_range(32, 36), $urandom_range(0, 2), $urandom_range(0, 1) != 0);
      else
        send_set($urandom_range(1, 9), $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0,
                 $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Summary: %0d points in %0d point sets, incl. single-point, tied, extreme",
             points_sent, builds);
    $display("and over-capacity sets, with random gaps and a full pause between sets.");
    if (fails == 0 && pending == 0) begin
      $display("farthest_insertion_tour_builder_tb passed");
    end else begin
      $display("farthest_insertion_tour_builder_tb failed");
    end
    $finish;
  end
endmodule
